/* sv/fte_pkg.sv */
// shared constants and types for the flag triggered window extractor
package fte_pkg;

  localparam int DEF_MAX_WINDOW = 64;
  localparam int DEF_ITEM_BYTES = 4;

  localparam int DATA_W = 32;
  localparam int LEN_W  = 7;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [LEN_W-1:0] LEN_RST = 7'd64;
  localparam logic [LEN_W-1:0] LEN_MASK = '1;

  typedef enum logic {
    REG_WINDOW_LENGTH  = 1'b0,
    REG_ADVANCE_LENGTH = 1'b1
  } cfg_reg_t;

endpackage

/* sv/flag_triggered_window_extractor_unit.sv */
// flag triggered window extractor: ring store of samples replayed as windows
// an item that completes no window is taken every cycle
// an item that completes a window holds in_tready low until window_length ring reads are done,
//   one per cycle while the output buffer has room; read words pass the ring read register
// results leave at one per cycle while out_tready is high, through a two word output buffer
// synchronous active-low reset clears marks, skip count, write position and output;
//   both length registers reset to 64, ring contents are not cleared
module flag_triggered_window_extractor_unit
  import fte_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int ITEM_BYTES = DEF_ITEM_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,     // sample_data
  input  logic [0:0]        in_tuser,     // trigger_flag
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,    // window_data
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WINDOW);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);
  localparam logic [7:0] DEPTH8 = 8'(MAX_WINDOW);
  localparam logic [DATA_W-1:0] ITEM_MASK = (ITEM_BYTES >= 4) ? '1 :
    DATA_W'((64'd1 << (8 * ITEM_BYTES)) - 64'd1);
  localparam logic [MAX_WINDOW-1:0] ONE_HOT0 = MAX_WINDOW'(1);

  logic [LEN_W-1:0]      wl_r, al_r, skip_r, skip_nxt, rem_r, rem_nxt;
  logic [AW-1:0]         pos_r, pos_nxt, rd_addr_r, rd_addr_nxt;
  logic [MAX_WINDOW-1:0] marks_r, marks_nxt, marks_wr, pos_hot, start_hot;
  logic                  rd_vld_r, rd_last_r;
  logic                  out_vld_r, out_vld_nxt, sk_vld_r, sk_vld_nxt;
  logic [DATA_W-1:0]     out_data_r, out_data_nxt, sk_data_r, sk_data_nxt;
  logic                  out_last_r, out_last_nxt, sk_last_r, sk_last_nxt;

  logic [LEN_W-1:0]  win_len, adv_len;
  logic [7:0]        start_sum;
  logic [AW-1:0]     start_slot;
  logic              in_acc, trig, fire, pop, issue, cfg_wr;
  logic [1:0]        occ;
  logic [DATA_W-1:0] rd_data;

  // effective lengths
  always_comb begin
    if (wl_r == '0) begin
      win_len = LEN_W'(1);
    end else if (wl_r > MAX_LEN) begin
      win_len = MAX_LEN;
    end else begin
      win_len = wl_r;
    end
    if (al_r == '0) begin
      adv_len = LEN_W'(1);
    end else if (al_r > win_len) begin
      adv_len = win_len;
    end else begin
      adv_len = al_r;
    end
  end

  assign in_tready = (rem_r == '0);
  assign in_acc    = in_tvalid && in_tready;

  // window start slot for a window ending at the current position
  assign start_sum  = 8'(pos_r) + DEPTH8 + 8'd1 - 8'(win_len);
  assign start_slot = (start_sum >= DEPTH8) ? AW'(start_sum - DEPTH8) : AW'(start_sum);
  assign pos_hot    = ONE_HOT0 << pos_r;
  assign start_hot  = ONE_HOT0 << start_slot;
  assign trig       = (skip_r == '0) && in_tuser[0];

  always_comb begin
    marks_wr = marks_r & ~pos_hot;
    if (trig) begin
      marks_wr = marks_wr | pos_hot;
    end
    fire = marks_wr[start_slot];
  end

  // output buffer occupancy and read issue
  assign pop   = out_vld_r && out_tready;
  assign occ   = 2'(out_vld_r) + 2'(sk_vld_r) + 2'(rd_vld_r);
  assign issue = (rem_r != '0) && ((occ != 2'd2) || pop);

  always_comb begin
    marks_nxt   = marks_r;
    skip_nxt    = skip_r;
    pos_nxt     = pos_r;
    rem_nxt     = rem_r;
    rd_addr_nxt = rd_addr_r;
    if (in_acc) begin
      marks_nxt = fire ? (marks_wr & ~start_hot) : marks_wr;
      if (trig) begin
        skip_nxt = adv_len - LEN_W'(1);
      end else if (skip_r != '0) begin
        skip_nxt = skip_r - LEN_W'(1);
      end
      pos_nxt = (pos_r == LAST_SLOT) ? '0 : pos_r + AW'(1);
      if (fire) begin
        rem_nxt     = win_len;
        rd_addr_nxt = start_slot;
      end
    end else if (issue) begin
      rem_nxt     = rem_r - LEN_W'(1);
      rd_addr_nxt = (rd_addr_r == LAST_SLOT) ? '0 : rd_addr_r + AW'(1);
    end
  end

  // head register plus skid register
  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    sk_vld_nxt   = sk_vld_r;
    sk_data_nxt  = sk_data_r;
    sk_last_nxt  = sk_last_r;
    if (pop && sk_vld_r) begin
      out_vld_nxt  = 1'b1;
      out_data_nxt = sk_data_r;
      out_last_nxt = sk_last_r;
      sk_vld_nxt   = rd_vld_r;
      sk_data_nxt  = rd_data;
      sk_last_nxt  = rd_last_r;
    end else if (pop || !out_vld_r) begin
      out_vld_nxt  = rd_vld_r;
      out_data_nxt = rd_data;
      out_last_nxt = rd_last_r;
    end else if (rd_vld_r) begin
      sk_vld_nxt  = 1'b1;
      sk_data_nxt = rd_data;
      sk_last_nxt = rd_last_r;
    end
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r      <= LEN_RST;
      al_r      <= LEN_RST;
      skip_r    <= '0;
      pos_r     <= '0;
      marks_r   <= '0;
      rem_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      sk_vld_r  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_reg_t'(cfg_paddr[2]))
          REG_WINDOW_LENGTH:  wl_r <= cfg_pwdata[LEN_W-1:0];
          REG_ADVANCE_LENGTH: al_r <= cfg_pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
      skip_r    <= skip_nxt;
      pos_r     <= pos_nxt;
      marks_r   <= marks_nxt;
      rem_r     <= rem_nxt;
      rd_vld_r  <= issue;
      out_vld_r <= out_vld_nxt;
      sk_vld_r  <= sk_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    rd_last_r  <= (rem_r == LEN_W'(1));
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    sk_data_r  <= sk_data_nxt;
    sk_last_r  <= sk_last_nxt;
  end

  fte_ring #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ring (
    .clk    (clk),
    .wr_en  (in_acc),
    .wr_addr(pos_r),
    .wr_data(in_tdata & ITEM_MASK),
    .rd_en  (issue),
    .rd_addr(rd_addr_r),
    .rd_data(rd_data)
  );

  always_comb begin
    unique case (cfg_reg_t'(cfg_paddr[2]))
      REG_WINDOW_LENGTH:  cfg_prdata = CFG_DW'(wl_r & LEN_MASK);
      REG_ADVANCE_LENGTH: cfg_prdata = CFG_DW'(al_r & LEN_MASK);
      default:            cfg_prdata = '0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* sv/fte_ring.sv */
// sample ring memory with one write port and one registered read port
module fte_ring
  import fte_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WINDOW)-1:0] wr_addr,
  input  logic [DATA_W-1:0]             wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WINDOW)-1:0] rd_addr,
  output logic [DATA_W-1:0]             rd_data
);

  logic [DATA_W-1:0] mem [MAX_WINDOW];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* sv/fte_chk.sv */
// port level checks for the window extractor, bound to the top level
module fte_chk
  import fte_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [DATA_W-1:0] in_tdata,
  input logic [0:0]        in_tuser,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata,
  input logic              out_tlast,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [CFG_AW-1:0] cfg_paddr,
  input logic [CFG_DW-1:0] cfg_pwdata,
  input logic [CFG_DW-1:0] cfg_prdata,
  input logic              cfg_pready
);

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed under stall");

  // a replay that holds input through the ring read and output registers has words on the output
  a_replay_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && $past(!in_tready) && $past(!in_tready, 2) |-> out_tvalid)
    else $error("replay stalled input without output words");

  // register readback
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cfg_wr) && cfg_psel && !cfg_pwrite && (cfg_paddr[2] == $past(cfg_paddr[2]))
    |-> cfg_prdata == ($past(cfg_pwdata) & CFG_DW'(LEN_MASK)))
    else $error("register readback mismatch");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("output word present after reset");

  a_reset_in: assert property (@(posedge clk)
    $past(!rst_n) |-> in_tready)
    else $error("input not ready after reset");

endmodule

bind flag_triggered_window_extractor_unit fte_chk u_fte_chk (.*);

/* dv/window_stream_checker.sv */
// window extractor checker: predicts extracted windows from accepted samples and compares
module window_stream_checker
  import fte_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,     // sample_data
  input  logic [0:0]        in_tuser,     // trigger_flag
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [DATA_W-1:0] out_tdata,    // window_data
  input  logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  input  logic              cfg_pready,
  output int                owed_words,
  output int                mismatch_count
);

  localparam int RING_DEPTH = DEF_MAX_WINDOW;
  localparam int POS_W      = $clog2(RING_DEPTH);

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } window_word_t;

  window_word_t      owed_q[$];
  window_word_t      want;
  logic [DATA_W-1:0] sample_store [RING_DEPTH];
  logic [RING_DEPTH-1:0] open_starts;
  logic [LEN_W-1:0]  skip_left;
  logic [POS_W-1:0]  next_slot;
  logic [LEN_W-1:0]  win_len;
  logic [LEN_W-1:0]  adv_len;
  int                miss_tally = 0;

  task automatic take_sample(input logic [DATA_W-1:0] d, input logic flag);
    int w;
    int a;
    int k;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] first;
    w = (win_len == '0) ? 1 : int'(win_len);
    if (w > RING_DEPTH) w = RING_DEPTH;
    a = (adv_len == '0) ? 1 : int'(adv_len);
    if (a > w) a = w;
    pos = next_slot;
    sample_store[pos] = d;
    open_starts[pos] = 1'b0;
    if (skip_left == '0) begin
      if (flag) begin
        open_starts[pos] = 1'b1;
        skip_left = LEN_W'(a - 1);
      end
    end else begin
      skip_left = skip_left - 1'b1;
    end
    first = pos - POS_W'(w - 1);
    if (open_starts[first]) begin
      open_starts[first] = 1'b0;
      for (k = 0; k < w; k++) begin
        owed_q.push_back(window_word_t'{data: sample_store[first + POS_W'(k)],
                                        last: (k == w - 1)});
      end
    end
    next_slot = pos + 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_q.delete();
      open_starts = '0;
      skip_left = '0;
      next_slot = '0;
      win_len = LEN_RST;
      adv_len = LEN_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        if (owed_q.size() == 0) begin
          $error("window word %h arrived with no window expected", out_tdata);
          miss_tally++;
        end else begin
          want = owed_q.pop_front();
          if (out_tdata !== want.data) begin
            $error("window_data expected %h actual %h", want.data, out_tdata);
            miss_tally++;
          end
          if (out_tlast !== want.last) begin
            $error("window_last expected %b actual %b", want.last, out_tlast);
            miss_tally++;
          end
        end
      end
      if (in_tvalid && in_tready) take_sample(in_tdata, in_tuser[0]);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_reg_t'(cfg_paddr[2]))
          REG_WINDOW_LENGTH: begin
            win_len = cfg_pwdata[LEN_W-1:0];
          end
          REG_ADVANCE_LENGTH: begin
            adv_len = cfg_pwdata[LEN_W-1:0];
          end
        endcase
      end
    end
    owed_words <= owed_q.size();
    mismatch_count <= miss_tally;
  end

endmodule

/* dv/tb_flag_triggered_window_extractor_unit.sv */
// testbench top for the window extractor: clock, reset, stimulus, stalls and verdict
module tb_flag_triggered_window_extractor_unit;
  import fte_pkg::*;

  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 2000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;     // sample_data
  logic [0:0]        in_tuser;     // trigger_flag
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;    // window_data
  logic              out_tlast;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int   owed_words;
  int   mismatch_count;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   quiet_cycles = 0;
  logic long_hold_req = 1'b0;

  flag_triggered_window_extractor_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  window_stream_checker u_window_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_pready     (cfg_pready),
    .owed_words     (owed_words),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, or one long hold-off when requested
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_reg_t which, input logic [LEN_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'({which, 2'b00});
    cfg_pwdata <= CFG_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_lengths(input logic [LEN_W-1:0] win, input logic [LEN_W-1:0] adv);
    write_reg(REG_WINDOW_LENGTH, win);
    write_reg(REG_ADVANCE_LENGTH, adv);
  endtask

  task automatic offer_sample(input logic [DATA_W-1:0] d, input logic flag);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= flag;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (owed_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] win, input logic [LEN_W-1:0] adv,
                           input int idle, input int stall, input int flag_pct,
                           input int count);
    logic [DATA_W-1:0] d;
    idle_pct = idle;
    stall_pct = stall;
    set_lengths(win, adv);
    repeat (count) begin
      case ($urandom_range(9))
        0: begin
          d = '0;
        end
        1: begin
          d = '1;
        end
        default: begin
          d = $urandom();
        end
      endcase
      offer_sample(d, $urandom_range(99) < flag_pct);
    end
    drain_results();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // overlapping windows, flag ignored while skipping
    set_lengths(4, 2);
    offer_sample(32'h0000_0000, 1'b0);
    offer_sample(32'hffff_ffff, 1'b1);
    offer_sample(32'h0000_0001, 1'b1);
    offer_sample(32'h8000_0000, 1'b1);
    offer_sample(32'haaaa_aaaa, 1'b0);
    offer_sample(32'h5555_5555, 1'b0);
    offer_sample(32'h1234_5678, 1'b0);
    drain_results();

    // one word windows, then zero lengths
    set_lengths(1, 1);
    offer_sample(32'hffff_ffff, 1'b1);
    offer_sample(32'h0000_0000, 1'b1);
    offer_sample(32'hdead_beef, 1'b0);
    drain_results();
    set_lengths(0, 0);
    offer_sample(32'h0f0f_0f0f, 1'b1);
    offer_sample(32'hf0f0_f0f0, 1'b1);
    drain_results();

    // window shortened while a start is pending
    set_lengths(6, 6);
    offer_sample(32'h1111_1111, 1'b1);
    offer_sample(32'h2222_2222, 1'b1);
    drain_results();
    write_reg(REG_WINDOW_LENGTH, 4);
    offer_sample(32'h3333_3333, 1'b0);
    offer_sample(32'h4444_4444, 1'b1);
    offer_sample(32'h5555_5555, 1'b1);
    drain_results();

    // advance above window length
    set_lengths(3, 100);
    offer_sample(32'h6666_6666, 1'b1);
    offer_sample(32'h7777_7777, 1'b0);
    offer_sample(32'h8888_8888, 1'b1);
    offer_sample(32'h9999_9999, 1'b1);
    offer_sample(32'hcccc_cccc, 1'b0);
    offer_sample(32'h7fff_ffff, 1'b0);
    drain_results();

    run_phase(5, 3, 0, 0, 30, 10);
    run_phase(127, 1, 58, 0, 8, 66);
    long_hold_req = 1'b1;
    run_phase(8, 0, 0, 58, 60, 12);
    run_phase(12, 20, 13, 13, 30, 10);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/fte_pkg.sv
sv/fte_ring.sv
sv/flag_triggered_window_extractor_unit.sv
sv/fte_chk.sv
dv/window_stream_checker.sv
dv/tb_flag_triggered_window_extractor_unit.sv
